### hdl/krqs_pkg.sv
package krqs_pkg;

	localparam int KEY_BITS = 64;
	localparam int INS_LIMIT = 7;
	localparam int STACK_DEPTH = 8;
	localparam int STK_PTR_BITS = 4;

	localparam logic [1:0] KIND_S32 = 2'd0;
	localparam logic [1:0] KIND_U32 = 2'd1;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_RANGE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_NEXT,
		ST_MID_RD,
		ST_MID_WR,
		ST_M1_RD,
		ST_M1_CMP,
		ST_M2_RD,
		ST_M2_CMP,
		ST_M3_RD,
		ST_M3_CMP,
		ST_SCAN_I,
		ST_SCAN_J,
		ST_SWAP_IJ,
		ST_FIN_RD,
		ST_FIN_WR,
		ST_POP,
		ST_EMIT
	} krqs_state_t;

	// Compare keys under the selected key kind: a strictly greater than b.
	function automatic logic key_gt(input logic [1:0] kind, input logic [KEY_BITS-1:0] a,
			input logic [KEY_BITS-1:0] b);
		logic [KEY_BITS-1:0] x;
		logic [KEY_BITS-1:0] y;
		begin
			x = a;
			y = b;
			if (kind == KIND_S32) begin
				x = {32'd0, a[31] ^ 1'b1, a[30:0]};
				y = {32'd0, b[31] ^ 1'b1, b[30:0]};
			end else if (kind == KIND_U32) begin
				x = {32'd0, a[31:0]};
				y = {32'd0, b[31:0]};
			end
			key_gt = x > y;
		end
	endfunction

endpackage

### hdl/krqs_in_fifo.sv
// Short record queue between the loader and the sort engine.
module krqs_in_fifo #(
	parameter int WIDTH = 97
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] buf_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = buf_q[rp_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			buf_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= ~wp_q;
			end
			if (do_rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end
endmodule

### hdl/krqs_engine.sv
// Record store, quicksort sequencer and output register.
module krqs_engine #(
	parameter int MAX_RECORDS  = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      kind,
	input  logic                            rec_valid,
	output logic                            rec_ready,
	input  logic [krqs_pkg::KEY_BITS-1:0]   rec_key,
	input  logic [PAYLOAD_BITS-1:0]         rec_pay,
	input  logic                            rec_final,
	output logic                            busy,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [krqs_pkg::KEY_BITS-1:0]   out_key,
	output logic [PAYLOAD_BITS-1:0]         out_pay,
	output logic                            out_last
);
	import krqs_pkg::*;

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = AW + 1;
	localparam int RW = KEY_BITS + PAYLOAD_BITS;

	logic [RW-1:0] mem [MAX_RECORDS];

	krqs_state_t state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d, p_q, p_d, q_d, q_q;
	logic [CW-1:0] stk_lo_q [STACK_DEPTH];
	logic [CW-1:0] stk_hi_q [STACK_DEPTH];
	logic [STK_PTR_BITS-1:0] lvl_q, lvl_d;
	logic [CW-1:0] xa_q, xb_q, xa_d, xb_d;
	logic          rd2_q, rd2_d;
	logic [CW-1:0] emit_q, emit_d;
	logic          push_en;
	logic [CW-1:0] push_lo, push_hi;

	// Memory access: address latched, data registered.
	logic [AW-1:0] rda_a, rda_b, wa_a, wa_b;
	logic          we_a, we_b;
	logic [RW-1:0] wd_a, wd_b;
	logic [RW-1:0] da_q, db_q;

	logic          ovalid_q;
	logic [RW-1:0] odata_q;
	logic          olast_q;
	logic          oload;

	logic gt_ab;
	assign gt_ab = key_gt(kind, da_q[RW-1 -: KEY_BITS], db_q[RW-1 -: KEY_BITS]);

	function automatic logic [AW-1:0] ad(input logic [CW-1:0] v);
		ad = v[AW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem[wa_a] <= wd_a;
		end
		if (we_b) begin
			mem[wa_b] <= wd_b;
		end
		da_q <= mem[rda_a];
		db_q <= mem[rda_b];
	end

	assign rec_ready = state_q == ST_LOAD;
	assign busy      = state_q != ST_LOAD || ovalid_q;
	assign out_valid = ovalid_q;
	assign out_key   = odata_q[RW-1 -: KEY_BITS];
	assign out_pay   = odata_q[PAYLOAD_BITS-1:0];
	assign out_last  = olast_q;

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		lo_d = lo_q; hi_d = hi_q; i_d = i_q; j_d = j_q; p_d = p_q; q_d = q_q;
		lvl_d = lvl_q;
		xa_d = xa_q; xb_d = xb_q;
		rd2_d = rd2_q;
		emit_d = emit_q;
		push_en = 1'b0; push_lo = lo_q; push_hi = hi_q;
		rda_a = ad(xa_q); rda_b = ad(xb_q);
		we_a = 1'b0; we_b = 1'b0; wa_a = ad(xa_q); wa_b = ad(xb_q);
		wd_a = db_q; wd_b = da_q;
		oload = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				wa_a = ad(fill_q);
				wd_a = {rec_key, rec_pay};
				if (rec_valid) begin
					if (fill_q < CW'(MAX_RECORDS)) begin
						we_a   = 1'b1;
						fill_d = fill_q + 1'b1;
					end
					if (rec_final) begin
						lo_d = '0;
						hi_d = (fill_q < CW'(MAX_RECORDS)) ? fill_q + 1'b1 : fill_q;
						lvl_d = '0;
						state_d = ST_RANGE;
					end
				end
			end
			ST_RANGE: begin
				if (hi_q - lo_q <= CW'(INS_LIMIT)) begin
					p_d = lo_q; q_d = lo_q + 1'b1;
					if (lo_q + 1'b1 < hi_q) begin
						xa_d = lo_q; xb_d = lo_q + 1'b1;
						state_d = ST_INS_RD;
					end else begin
						state_d = ST_POP;
					end
				end else begin
					xa_d = lo_q + ((hi_q - lo_q) >> 1);
					xb_d = lo_q;
					rd2_d = 1'b0;
					state_d = ST_MID_RD;
				end
			end
			// Insertion sort: compare p with p+1, swap and step back.
			ST_INS_RD: begin
				rda_a = ad(xa_q); rda_b = ad(xb_q);
				state_d = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				if (gt_ab) begin
					we_a = 1'b1; we_b = 1'b1;
					wa_a = ad(p_q); wd_a = db_q;
					wa_b = ad(p_q + 1'b1); wd_b = da_q;
					if (p_q == lo_q) begin
						state_d = ST_INS_NEXT;
					end else begin
						p_d = p_q - 1'b1;
						xa_d = p_q - 1'b1; xb_d = p_q;
						state_d = ST_INS_RD;
					end
				end else begin
					state_d = ST_INS_NEXT;
				end
			end
			ST_INS_NEXT: begin
				p_d = q_q; q_d = q_q + 1'b1;
				if (q_q + 1'b1 < hi_q) begin
					xa_d = q_q; xb_d = q_q + 1'b1;
					state_d = ST_INS_RD;
				end else begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (lvl_q == '0) begin
					emit_d = '0;
					state_d = ST_EMIT;
				end else begin
					lvl_d = lvl_q - 1'b1;
					lo_d = stk_lo_q[lvl_q[STK_PTR_BITS-2:0] - 1'b1];
					hi_d = stk_hi_q[lvl_q[STK_PTR_BITS-2:0] - 1'b1];
					if (stk_hi_q[lvl_q[STK_PTR_BITS-2:0] - 1'b1] <
							stk_lo_q[lvl_q[STK_PTR_BITS-2:0] - 1'b1]) begin
						hi_d = stk_lo_q[lvl_q[STK_PTR_BITS-2:0] - 1'b1];
					end
					state_d = ST_RANGE;
				end
			end
			// Swap middle record to lo.
			ST_MID_RD: begin
				rda_a = ad(xa_q); rda_b = ad(xb_q);
				state_d = ST_MID_WR;
			end
			ST_MID_WR: begin
				we_a = 1'b1; we_b = 1'b1;
				wd_a = db_q; wd_b = da_q;
				i_d = lo_q + 1'b1; j_d = hi_q - 1'b1;
				xa_d = lo_q + 1'b1; xb_d = hi_q - 1'b1;
				state_d = ST_M1_RD;
			end
			ST_M1_RD: begin
				state_d = ST_M1_CMP;
			end
			ST_M1_CMP: begin
				if (gt_ab) begin
					we_a = 1'b1; we_b = 1'b1; wd_a = db_q; wd_b = da_q;
				end
				xa_d = lo_q; xb_d = j_q;
				state_d = ST_M2_RD;
			end
			ST_M2_RD: begin
				state_d = ST_M2_CMP;
			end
			ST_M2_CMP: begin
				if (gt_ab) begin
					we_a = 1'b1; we_b = 1'b1; wd_a = db_q; wd_b = da_q;
					xa_d = i_q; xb_d = lo_q;
					state_d = ST_SCAN_I;
					rd2_d = 1'b0;
				end else begin
					xa_d = i_q; xb_d = lo_q;
					state_d = ST_M3_RD;
				end
			end
			ST_M3_RD: begin
				state_d = ST_M3_CMP;
			end
			ST_M3_CMP: begin
				if (gt_ab) begin
					we_a = 1'b1; we_b = 1'b1; wd_a = db_q; wd_b = da_q;
				end
				rd2_d = 1'b0;
				state_d = ST_SCAN_I;
			end
			// Scan i upward while pivot > a[i]; rd2_q marks data ready.
			ST_SCAN_I: begin
				rda_a = ad(lo_q); rda_b = ad(i_q + 1'b1);
				if (!rd2_q) begin
					i_d = i_q + 1'b1;
					rd2_d = 1'b1;
					if (!(i_q + 1'b1 < hi_q - 1'b1)) begin
						rd2_d = 1'b0;
						state_d = ST_SCAN_J;
					end
				end else begin
					rda_b = ad(i_q);
					if (gt_ab) begin
						rd2_d = 1'b0;
					end else begin
						rd2_d = 1'b0;
						state_d = ST_SCAN_J;
					end
					rda_b = ad(i_q + 1'b1);
				end
			end
			ST_SCAN_J: begin
				rda_a = ad(j_q - 1'b1); rda_b = ad(lo_q);
				if (!rd2_q) begin
					j_d = j_q - 1'b1;
					rd2_d = 1'b1;
					if (!(j_q - 1'b1 > lo_q)) begin
						rd2_d = 1'b0;
						state_d = ST_SWAP_IJ;
					end
				end else begin
					rd2_d = 1'b0;
					if (!gt_ab) begin
						state_d = ST_SWAP_IJ;
					end
				end
				rda_a = ad(j_q - 1'b1);
			end
			ST_SWAP_IJ: begin
				xa_d = i_q; xb_d = j_q;
				if (i_q > j_q) begin
					xa_d = lo_q;
					state_d = ST_FIN_RD;
				end else if (!rd2_q) begin
					rd2_d = 1'b1;
				end else begin
					rd2_d = 1'b0;
					state_d = ST_INS_RD;
				end
				rda_a = ad(i_q); rda_b = ad(j_q);
				if (rd2_q && !(i_q > j_q)) begin
					we_a = 1'b1; we_b = 1'b1;
					wa_a = ad(i_q); wa_b = ad(j_q);
					wd_a = db_q; wd_b = da_q;
					state_d = ST_SCAN_I;
				end
			end
			ST_FIN_RD: begin
				state_d = ST_FIN_WR;
			end
			ST_FIN_WR: begin
				we_a = 1'b1; we_b = 1'b1; wd_a = db_q; wd_b = da_q;
				push_en = 1'b1;
				if (j_q - lo_q > hi_q - i_q) begin
					push_lo = lo_q; push_hi = j_q; lo_d = i_q;
				end else begin
					push_lo = i_q; push_hi = hi_q; hi_d = j_q;
				end
				if (lvl_q < STK_PTR_BITS'(STACK_DEPTH)) begin
					lvl_d = lvl_q + 1'b1;
				end
				state_d = ST_RANGE;
			end
			ST_EMIT: begin
				rda_a = ad(emit_q);
				if (!rd2_q) begin
					rd2_d = 1'b1;
				end else if (!ovalid_q || out_ready) begin
					oload = 1'b1;
					rd2_d = 1'b0;
					emit_d = emit_q + 1'b1;
					if (emit_q + 1'b1 == fill_q) begin
						fill_d = '0;
						state_d = ST_LOAD;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_en && lvl_q < STK_PTR_BITS'(STACK_DEPTH)) begin
			stk_lo_q[lvl_q[STK_PTR_BITS-2:0]] <= push_lo;
			stk_hi_q[lvl_q[STK_PTR_BITS-2:0]] <= push_hi;
		end
		lo_q <= lo_d; hi_q <= hi_d; i_q <= i_d; j_q <= j_d; p_q <= p_d; q_q <= q_d;
		xa_q <= xa_d; xb_q <= xb_d;
		emit_q <= emit_d;
		if (oload) begin
			odata_q <= da_q;
			olast_q <= emit_q + 1'b1 == fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			fill_q   <= '0;
			lvl_q    <= '0;
			rd2_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			lvl_q   <= lvl_d;
			rd2_q   <= rd2_d;
			if (oload) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end
endmodule

### hdl/keyed_record_quicksort.sv
// Channel  | handshake                  | payload
// cfg      | cfg_valid / cfg_ready      | cfg_data (key_kind)
// input    | in_valid / in_ready        | sort_key, record_payload, final_record
// output   | out_valid / out_ready      | sorted_key, sorted_payload, last_out
//
// Loading takes one record per cycle, while the engine waits for records,
// through a two-entry queue. The final record starts the sort: a median-of-three
// quicksort on one two-port record memory, each compare taking a read state and
// a compare state. Output reads each record from memory, then loads it into the
// output register. Reset clears control state only; memory needs no clearing.
// Output stalls hold the engine; input stalls back up into the queue.
module keyed_record_quicksort #(
	parameter int MAX_RECORDS  = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [krqs_pkg::KEY_BITS-1:0] sort_key,
	input  logic [PAYLOAD_BITS-1:0]       record_payload,
	input  logic                          final_record,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [krqs_pkg::KEY_BITS-1:0] sorted_key,
	output logic [PAYLOAD_BITS-1:0]       sorted_payload,
	output logic                          last_out
);
	import krqs_pkg::*;

	localparam int QW = KEY_BITS + PAYLOAD_BITS + 1;

	logic [1:0]    kind_q;
	logic          q_valid, q_ready, busy;
	logic [QW-1:0] q_data;

	// Hold the key kind; accept a write only while no record waits in the
	// queue and the engine is neither sorting nor emitting.
	assign cfg_ready = !busy && !q_valid;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_S32;
		end else if (cfg_valid && cfg_ready) begin
			kind_q <= cfg_data;
		end
	end

	krqs_in_fifo #(.WIDTH(QW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(in_valid), .wr_ready(in_ready),
		.wr_data({sort_key, record_payload, final_record}),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
	);

	krqs_engine #(.MAX_RECORDS(MAX_RECORDS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_eng (
		.clk(clk), .arst_n(arst_n), .kind(kind_q),
		.rec_valid(q_valid), .rec_ready(q_ready),
		.rec_key(q_data[QW-1 -: KEY_BITS]),
		.rec_pay(q_data[PAYLOAD_BITS:1]),
		.rec_final(q_data[0]),
		.busy(busy),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_key(sorted_key), .out_pay(sorted_payload), .out_last(last_out)
	);
endmodule
